// ----- hdl/trsc_pkg.sv -----
`timescale 1ns / 1ps
// Shared types and constants for the throttle ramp speed controller.
// No dependencies; every other file imports this package.

package trsc_pkg;

    // Field widths
    localparam int ADC_W    = 10;
    localparam int DUTY_W   = 8;
    localparam int STEP_W   = 16;
    localparam int CFG_IX_W = 3;
    localparam int CFG_D_W  = 16;

    // Divider geometry: dividend covers 1023 * 254, divisor a 10-bit span
    localparam int DIV_N_W  = 18;
    localparam int DIV_D_W  = 10;
    localparam int DIV_C_W  = 5;

    localparam logic [DIV_D_W-1:0] ADC_MAX  = 10'd1023;
    localparam logic [DUTY_W-1:0]  CEIL_MAX = 8'd254;

    // Register indexes
    localparam logic [CFG_IX_W-1:0] CFG_ACCEL_STEP    = 3'd0;
    localparam logic [CFG_IX_W-1:0] CFG_COAST_STEP    = 3'd1;
    localparam logic [CFG_IX_W-1:0] CFG_BRAKE_STEP    = 3'd2;
    localparam logic [CFG_IX_W-1:0] CFG_MIN_SPEED     = 3'd3;
    localparam logic [CFG_IX_W-1:0] CFG_THROTTLE_LOW  = 3'd4;
    localparam logic [CFG_IX_W-1:0] CFG_THROTTLE_HIGH = 3'd5;
    localparam logic [CFG_IX_W-1:0] CFG_IDLE_LIMIT    = 3'd6;

    // Register reset values
    localparam logic [STEP_W-1:0] RST_ACCEL_STEP    = 16'd2048;
    localparam logic [STEP_W-1:0] RST_COAST_STEP    = 16'd1365;
    localparam logic [STEP_W-1:0] RST_BRAKE_STEP    = 16'd6400;
    localparam logic [DUTY_W-1:0] RST_MIN_SPEED     = 8'd20;
    localparam logic [ADC_W-1:0]  RST_THROTTLE_LOW  = 10'd0;
    localparam logic [ADC_W-1:0]  RST_THROTTLE_HIGH = 10'd17;
    localparam logic [STEP_W-1:0] RST_IDLE_LIMIT    = 16'd200;

    typedef struct packed {
        logic [STEP_W-1:0] accel_step;
        logic [STEP_W-1:0] coast_step;
        logic [STEP_W-1:0] brake_step;
        logic [DUTY_W-1:0] min_speed;
        logic [ADC_W-1:0]  throttle_low;
        logic [ADC_W-1:0]  throttle_high;
        logic [STEP_W-1:0] idle_limit;
    } t_cfg;

    typedef struct packed {
        logic               start;
        logic [DIV_N_W-1:0] dividend;
        logic [DIV_D_W-1:0] divisor;
    } t_div_req;

    typedef struct packed {
        logic               done;
        logic [DIV_N_W-1:0] quotient;
    } t_div_rsp;

    typedef struct packed {
        logic [DUTY_W-1:0] pwm_duty;
        logic              power_off;
    } t_tick_out;

endpackage

// ----- hdl/trsc_div.sv -----
`timescale 1ns / 1ps
// Restoring divider, one quotient bit per cycle, used for the throttle
// to target mapping. Depends on trsc_pkg.

module trsc_div (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  trsc_pkg::t_div_req  i_req,
    output trsc_pkg::t_div_rsp  o_rsp
);
    import trsc_pkg::*;

    logic               r_busy;
    logic               r_done;
    logic [DIV_C_W-1:0] r_cnt;
    logic [DIV_D_W-1:0] r_rem;
    logic [DIV_N_W-1:0] r_quo;
    logic [DIV_D_W-1:0] r_dvs;

    logic [DIV_D_W:0]   shifted;
    logic [DIV_D_W+1:0] diff;
    logic               fits;

    assign shifted = {r_rem, r_quo[DIV_N_W-1]};
    assign diff    = {1'b0, shifted} - {2'b00, r_dvs};
    assign fits    = ~diff[DIV_D_W+1];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_req.start) begin
                r_busy <= 1'b1;
                r_cnt  <= DIV_C_W'(DIV_N_W - 1);
            end else if (r_busy) begin
                if (r_cnt == '0) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end else begin
                    r_cnt <= r_cnt - 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_req.start) begin
            r_rem <= '0;
            r_quo <= i_req.dividend;
            r_dvs <= i_req.divisor;
        end else if (r_busy) begin
            // keep the trial difference when the divisor fits
            r_rem <= fits ? diff[DIV_D_W-1:0] : shifted[DIV_D_W-1:0];
            r_quo <= {r_quo[DIV_N_W-2:0], fits};
        end
    end

    assign o_rsp.done     = r_done;
    assign o_rsp.quotient = r_quo;

endmodule

// ----- hdl/trsc_state.sv -----
`timescale 1ns / 1ps
// Speed ramp, idle counter and power-off latch, updated once per tick.
// Depends on trsc_pkg.

module trsc_state (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_commit,
    input  logic                          i_released,
    input  logic [trsc_pkg::DIV_N_W-1:0]  i_target,
    input  logic [trsc_pkg::DUTY_W-1:0]   i_ceiling,
    input  trsc_pkg::t_cfg                i_cfg,
    output trsc_pkg::t_tick_out           o_next
);
    import trsc_pkg::*;

    logic [STEP_W-1:0] r_speed;
    logic [STEP_W-1:0] r_idle;
    logic              r_latch;

    logic [STEP_W-1:0] n_speed;
    logic [STEP_W-1:0] n_idle;
    logic              n_latch;

    logic [DIV_N_W-1:0] target;
    logic [STEP_W-1:0]  min_q;
    logic [STEP_W-1:0]  ceil_q;
    logic               below;
    logic [STEP_W:0]    sum;
    logic [STEP_W-1:0]  up;
    logic [STEP_W-1:0]  dec;
    logic [STEP_W:0]    down;

    always_comb begin
        // drop targets under the minimum running speed
        target = (i_target < {{(DIV_N_W-DUTY_W){1'b0}}, i_cfg.min_speed}) ? '0 : i_target;
        min_q  = {i_cfg.min_speed, 8'h00};
        ceil_q = {i_ceiling, 8'h00};
        below  = {{(DIV_N_W-DUTY_W){1'b0}}, r_speed} < {target, 8'h00};

        sum = {1'b0, r_speed} + {1'b0, i_cfg.accel_step};
        up  = (sum > {1'b0, ceil_q}) ? ceil_q : sum[STEP_W-1:0];
        if (up < min_q) begin
            up = min_q;
        end

        dec  = i_released ? i_cfg.coast_step : i_cfg.brake_step;
        down = {1'b0, r_speed} - {1'b0, dec};

        if (i_released && below) begin
            n_speed = up;
        end else if (down[STEP_W] || (down[STEP_W-1:0] < min_q)) begin
            n_speed = '0;
        end else begin
            n_speed = down[STEP_W-1:0];
        end

        if ((target != '0) || !i_released) begin
            n_idle = '0;
        end else if (r_idle != '1) begin
            n_idle = r_idle + 1'b1;
        end else begin
            n_idle = r_idle;
        end

        n_latch = r_latch | (n_idle > i_cfg.idle_limit);

        o_next.pwm_duty  = n_latch ? '0 : n_speed[STEP_W-1:8];
        o_next.power_off = n_latch;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_speed <= '0;
            r_idle  <= '0;
            r_latch <= 1'b0;
        end else if (i_commit) begin
            r_speed <= n_speed;
            r_idle  <= n_idle;
            r_latch <= n_latch;
        end
    end

endmodule

// ----- hdl/throttle_ramp_speed_controller_top.sv -----
`timescale 1ns / 1ps
// Sequence per word: accept, divider start, 18 quotient steps in the divider, quotient capture
// and the update; with an empty throttle window the word goes from accept straight to the update.
// The block takes no new word until the current one has committed its result.
// The result register lets the next word in while a result waits; a stalled result holds the update.
// Reset (synchronous, active low) clears speed, idle count, power latch and loads
// the register defaults. Depends on trsc_pkg, trsc_div, trsc_state.

module throttle_ramp_speed_controller_top (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_valid,
    output logic                            o_stall,
    input  logic [trsc_pkg::ADC_W-1:0]      i_throttle_sample,
    input  logic [trsc_pkg::ADC_W-1:0]      i_top_sample,
    input  logic                            i_brake_released,
    output logic                            o_valid,
    input  logic                            i_stall,
    output logic [trsc_pkg::DUTY_W-1:0]     o_pwm_duty,
    output logic [trsc_pkg::DUTY_W-1:0]     o_speed_ceiling,
    output logic                            o_power_off,
    input  logic                            i_cfg_valid,
    output logic                            o_cfg_ready,
    input  logic [trsc_pkg::CFG_IX_W-1:0]   i_cfg_index,
    input  logic [trsc_pkg::CFG_D_W-1:0]    i_cfg_data
);
    import trsc_pkg::*;

    typedef enum logic [3:0] {
        S_IDLE = 4'b0001,
        S_MUL  = 4'b0010,
        S_TGT  = 4'b0100,
        S_UPD  = 4'b1000
    } t_state;

    t_state r_state, n_state;

    t_cfg               r_cfg;
    logic [ADC_W-1:0]   r_thr;
    logic               r_released;
    logic [DUTY_W-1:0]  r_ceiling;
    logic [DIV_N_W-1:0] r_target;
    logic               r_neg;

    logic               r_valid;
    logic [DUTY_W-1:0]  r_pwm;
    logic [DUTY_W-1:0]  r_ceil_out;
    logic               r_poff;

    t_div_req  div_req;
    t_div_rsp  div_rsp;
    t_tick_out next_out;

    logic               in_acc;
    logic               out_free;
    logic               commit;
    logic               win_empty;
    logic [DIV_N_W-1:0] ceil_prod;
    logic [DIV_N_W-1:0] ceil_sum;
    logic [DUTY_W-1:0]  ceil_val;
    logic [ADC_W:0]     num_d;
    logic [ADC_W:0]     den_d;
    logic [ADC_W:0]     num_n;
    logic [ADC_W:0]     den_n;
    logic [ADC_W-1:0]   num_mag;
    logic [ADC_W-1:0]   den_mag;

    assign o_stall     = (r_state != S_IDLE);
    assign o_cfg_ready = 1'b1;
    assign in_acc      = i_valid && (r_state == S_IDLE);
    assign out_free    = !r_valid || !i_stall;
    assign commit      = (r_state == S_UPD) && out_free;
    assign win_empty   = (r_cfg.throttle_high == r_cfg.throttle_low);

    // ceiling = top * 254 / 1023; (x + x/1024 + 1) / 1024 is exact for quotients below 1023
    always_comb begin
        ceil_prod = {i_top_sample, 8'h00} - {7'd0, i_top_sample, 1'b0};
        ceil_sum  = ceil_prod + {{(DIV_N_W-DUTY_W){1'b0}}, ceil_prod[DIV_N_W-1:ADC_W]}
                    + DIV_N_W'(1);
        ceil_val  = ceil_sum[DIV_N_W-1:ADC_W];
    end

    always_comb begin
        num_d   = {1'b0, r_thr} - {1'b0, r_cfg.throttle_low};
        den_d   = {1'b0, r_cfg.throttle_high} - {1'b0, r_cfg.throttle_low};
        num_n   = -num_d;
        den_n   = -den_d;
        num_mag = num_d[ADC_W] ? num_n[ADC_W-1:0] : num_d[ADC_W-1:0];
        den_mag = den_d[ADC_W] ? den_n[ADC_W-1:0] : den_d[ADC_W-1:0];
    end

    // divider request: target magnitude once the word is held
    assign div_req.start    = (r_state == S_MUL);
    assign div_req.dividend = DIV_N_W'(num_mag) * DIV_N_W'(r_ceiling);
    assign div_req.divisor  = den_mag;

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_IDLE: if (i_valid) n_state = win_empty ? S_UPD : S_MUL;
            S_MUL:  n_state = S_TGT;
            S_TGT:  if (div_rsp.done) n_state = S_UPD;
            S_UPD:  if (out_free) n_state = S_IDLE;
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.accel_step    <= RST_ACCEL_STEP;
            r_cfg.coast_step    <= RST_COAST_STEP;
            r_cfg.brake_step    <= RST_BRAKE_STEP;
            r_cfg.min_speed     <= RST_MIN_SPEED;
            r_cfg.throttle_low  <= RST_THROTTLE_LOW;
            r_cfg.throttle_high <= RST_THROTTLE_HIGH;
            r_cfg.idle_limit    <= RST_IDLE_LIMIT;
        end else if (i_cfg_valid) begin
            unique case (i_cfg_index)
                CFG_ACCEL_STEP:    r_cfg.accel_step    <= i_cfg_data;
                CFG_COAST_STEP:    r_cfg.coast_step    <= i_cfg_data;
                CFG_BRAKE_STEP:    r_cfg.brake_step    <= i_cfg_data;
                CFG_MIN_SPEED:     r_cfg.min_speed     <= i_cfg_data[DUTY_W-1:0];
                CFG_THROTTLE_LOW:  r_cfg.throttle_low  <= i_cfg_data[ADC_W-1:0];
                CFG_THROTTLE_HIGH: r_cfg.throttle_high <= i_cfg_data[ADC_W-1:0];
                CFG_IDLE_LIMIT:    r_cfg.idle_limit    <= i_cfg_data;
                default: ;
            endcase
        end
    end

    // datapath holding registers
    always_ff @(posedge i_clk) begin
        if (in_acc) begin
            r_thr      <= i_throttle_sample;
            r_released <= i_brake_released;
            r_ceiling  <= ceil_val;
            r_target   <= {{(DIV_N_W-DUTY_W){1'b0}}, ceil_val};
        end
        if (r_state == S_MUL) begin
            r_neg <= num_d[ADC_W] ^ den_d[ADC_W];
        end
        if ((r_state == S_TGT) && div_rsp.done) begin
            // a negative quotient drops to zero target
            r_target <= r_neg ? '0 : div_rsp.quotient;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid    <= 1'b0;
            r_pwm      <= '0;
            r_ceil_out <= '0;
            r_poff     <= 1'b0;
        end else begin
            if (r_valid && !i_stall) begin
                r_valid <= 1'b0;
            end
            if (commit) begin
                r_valid    <= 1'b1;
                r_pwm      <= next_out.pwm_duty;
                r_ceil_out <= r_ceiling;
                r_poff     <= next_out.power_off;
            end
        end
    end

    trsc_div u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (div_req),
        .o_rsp   (div_rsp)
    );

    trsc_state u_state (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_commit   (commit),
        .i_released (r_released),
        .i_target   (r_target),
        .i_ceiling  (r_ceiling),
        .i_cfg      (r_cfg),
        .o_next     (next_out)
    );

    assign o_valid         = r_valid;
    assign o_pwm_duty      = r_pwm;
    assign o_speed_ceiling = r_ceil_out;
    assign o_power_off     = r_poff;

endmodule

// ----- hdl/trsc_checker.sv -----
`timescale 1ns / 1ps
// Port-level checks for the speed controller top, attached by bind.
// Depends on trsc_pkg and throttle_ramp_speed_controller_top.

module trsc_checker (
    input logic                          i_clk,
    input logic                          i_rst_n,
    input logic                          i_valid,
    input logic                          o_stall,
    input logic                          o_valid,
    input logic                          i_stall,
    input logic [trsc_pkg::DUTY_W-1:0]   o_pwm_duty,
    input logic [trsc_pkg::DUTY_W-1:0]   o_speed_ceiling,
    input logic                          o_power_off
);
    import trsc_pkg::*;

    // power-off is sticky until reset
    a_poff_sticky: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_power_off |=> o_power_off)
        else $error("power_off dropped without reset");

    a_poff_duty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && o_power_off) |-> (o_pwm_duty == '0))
        else $error("nonzero duty after power-off");

    a_ceil_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> (o_speed_ceiling <= CEIL_MAX))
        else $error("ceiling out of range");

    // an accepted word keeps the block busy on the next cycle
    a_busy_after_acc: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_valid && !o_stall) |=> o_stall)
        else $error("input not held off after accept");

    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && i_stall) |=> (o_valid && $stable(o_pwm_duty) && $stable(o_power_off)))
        else $error("stalled result changed");

endmodule

bind throttle_ramp_speed_controller_top trsc_checker u_trsc_checker (
    .i_clk           (i_clk),
    .i_rst_n         (i_rst_n),
    .i_valid         (i_valid),
    .o_stall         (o_stall),
    .o_valid         (o_valid),
    .i_stall         (i_stall),
    .o_pwm_duty      (o_pwm_duty),
    .o_speed_ceiling (o_speed_ceiling),
    .o_power_off     (o_power_off)
);

// ----- tb/sv/throttle_ramp_speed_controller_top_test.sv -----
`timescale 1ns / 1ps
// Self-checking testbench for throttle_ramp_speed_controller_top: directed ticks, window
// corner cases, random drive cycles under several register settings, idle power-off latch.
// Depends on trsc_pkg and the controller RTL.

module throttle_ramp_speed_controller_top_test;
    import trsc_pkg::*;

    localparam logic [CFG_IX_W-1:0] CFG_UNUSED = 3'd7;
    localparam int IDLE_SAT = 65535;
    localparam int Q8_MAX   = 65535;

    typedef struct packed {
        logic [DUTY_W-1:0] pwm_duty;
        logic [DUTY_W-1:0] speed_ceiling;
        logic              power_off;
    } t_tick_result;

    logic                i_clk = 1'b0;
    logic                i_rst_n;
    logic                i_valid;
    logic                o_stall;
    logic [ADC_W-1:0]    i_throttle_sample;
    logic [ADC_W-1:0]    i_top_sample;
    logic                i_brake_released;
    logic                o_valid;
    logic                i_stall;
    logic [DUTY_W-1:0]   o_pwm_duty;
    logic [DUTY_W-1:0]   o_speed_ceiling;
    logic                o_power_off;
    logic                i_cfg_valid;
    logic                o_cfg_ready;
    logic [CFG_IX_W-1:0] i_cfg_index;
    logic [CFG_D_W-1:0]  i_cfg_data;

    t_cfg         cfg_shadow;
    int           motor_speed;
    int           idle_count;
    bit           power_cut;
    t_tick_result expected_ticks[$];
    int           mismatches = 0;
    bit           send_gaps = 1'b0;
    bit           recv_stalls = 1'b0;

    throttle_ramp_speed_controller_top DUT (.*);

    always #5 i_clk = ~i_clk;

    // One control tick of the controller, advancing the shadow state.
    function automatic t_tick_result ramp_tick(logic [ADC_W-1:0] thr, logic [ADC_W-1:0] top,
                                               logic released);
        t_tick_result r;
        int ceiling;
        int lo;
        int hi;
        int minv;
        int target;
        int spd;
        ceiling = (int'(top) * int'(CEIL_MAX)) / int'(ADC_MAX);
        lo      = int'(cfg_shadow.throttle_low);
        hi      = int'(cfg_shadow.throttle_high);
        minv    = int'(cfg_shadow.min_speed);
        if (hi == lo) begin
            target = ceiling;
        end else begin
            target = ((int'(thr) - lo) * ceiling) / (hi - lo);
        end
        if (target < minv) begin
            target = 0;
        end
        spd = motor_speed;
        if (released) begin
            if (spd < target * 256) begin
                spd += int'(cfg_shadow.accel_step);
                if (spd > ceiling * 256) spd = ceiling * 256;
                if (spd < minv * 256) spd = minv * 256;
            end else begin
                spd -= int'(cfg_shadow.coast_step);
                if (spd < minv * 256) spd = 0;
            end
        end else begin
            spd -= int'(cfg_shadow.brake_step);
            if (spd < minv * 256) spd = 0;
        end
        if (spd < 0) spd = 0;
        if (spd > Q8_MAX) spd = Q8_MAX;
        motor_speed = spd;
        if (target != 0 || !released) begin
            idle_count = 0;
        end else if (idle_count < IDLE_SAT) begin
            idle_count++;
        end
        if (idle_count > int'(cfg_shadow.idle_limit)) begin
            power_cut = 1'b1;
        end
        r.pwm_duty      = power_cut ? '0 : motor_speed[15:8];
        r.speed_ceiling = ceiling[DUTY_W-1:0];
        r.power_off     = power_cut;
        return r;
    endfunction

    // Valid stays high across back-to-back words; drop it only for a gap.
    task automatic send_tick(int thr, int top, bit released);
        int gap;
        gap = (send_gaps && $urandom_range(0, 5) == 0) ? $urandom_range(1, 15) : 0;
        @(negedge i_clk);
        if (gap > 0) begin
            i_valid <= 1'b0;
            repeat (gap) @(negedge i_clk);
        end
        i_valid           <= 1'b1;
        i_throttle_sample <= thr[ADC_W-1:0];
        i_top_sample      <= top[ADC_W-1:0];
        i_brake_released  <= released;
        @(posedge i_clk);
        while (o_stall) @(posedge i_clk);
        expected_ticks.push_back(ramp_tick(thr[ADC_W-1:0], top[ADC_W-1:0], released));
    endtask

    task automatic wait_results_drained();
        @(negedge i_clk);
        i_valid <= 1'b0;
        while (expected_ticks.size() != 0) @(posedge i_clk);
        repeat (4) @(posedge i_clk);
    endtask

    task automatic write_reg(logic [CFG_IX_W-1:0] idx, int unsigned value);
        @(negedge i_clk);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= value[CFG_D_W-1:0];
        @(posedge i_clk);
        while (!o_cfg_ready) @(posedge i_clk);
        case (idx)
            CFG_ACCEL_STEP:    cfg_shadow.accel_step    = value[STEP_W-1:0];
            CFG_COAST_STEP:    cfg_shadow.coast_step    = value[STEP_W-1:0];
            CFG_BRAKE_STEP:    cfg_shadow.brake_step    = value[STEP_W-1:0];
            CFG_MIN_SPEED:     cfg_shadow.min_speed     = value[DUTY_W-1:0];
            CFG_THROTTLE_LOW:  cfg_shadow.throttle_low  = value[ADC_W-1:0];
            CFG_THROTTLE_HIGH: cfg_shadow.throttle_high = value[ADC_W-1:0];
            CFG_IDLE_LIMIT:    cfg_shadow.idle_limit    = value[STEP_W-1:0];
            default: ;
        endcase
        @(negedge i_clk);
        i_cfg_valid <= 1'b0;
    endtask

    task automatic apply_cfg(t_cfg c);
        write_reg(CFG_ACCEL_STEP, c.accel_step);
        write_reg(CFG_COAST_STEP, c.coast_step);
        write_reg(CFG_BRAKE_STEP, c.brake_step);
        write_reg(CFG_MIN_SPEED, c.min_speed);
        write_reg(CFG_THROTTLE_LOW, c.throttle_low);
        write_reg(CFG_THROTTLE_HIGH, c.throttle_high);
        write_reg(CFG_IDLE_LIMIT, c.idle_limit);
    endtask

    // Drive cycles: runs of held throttle and top readings with jitter, some braking,
    // and an occasional stray reading.
    task automatic drive_random(int count);
        int sent;
        int run_len;
        int mode;
        int thr_base;
        int top_base;
        int thr;
        int top;
        bit braking;
        bit released;
        sent = 0;
        while (sent < count) begin
            run_len = $urandom_range(1, 30);
            mode    = $urandom_range(0, 9);
            case (mode)
                0:       thr_base = 0;
                1:       thr_base = 1023;
                2:       thr_base = cfg_shadow.throttle_low;
                3:       thr_base = cfg_shadow.throttle_high;
                default: thr_base = $urandom_range(0, 1023);
            endcase
            top_base = ($urandom_range(0, 3) == 0) ? $urandom_range(0, 1023)
                                                   : $urandom_range(600, 1023);
            braking  = ($urandom_range(0, 4) == 0);
            for (int k = 0; k < run_len && sent < count; k++) begin
                thr = thr_base + int'($urandom_range(0, 6)) - 3;
                top = top_base + int'($urandom_range(0, 4)) - 2;
                if ($urandom_range(0, 15) == 0) thr = $urandom_range(0, 1023);
                if ($urandom_range(0, 15) == 0) top = $urandom_range(0, 1023);
                if (thr < 0) thr = 0;
                if (thr > 1023) thr = 1023;
                if (top < 0) top = 0;
                if (top > 1023) top = 1023;
                released = !braking;
                if ($urandom_range(0, 9) == 0) released = !released;
                send_tick(thr, top, released);
                sent++;
                // hold off until the pipeline is empty once per call
                if (sent == count / 2) wait_results_drained();
            end
        end
    endtask

    task automatic test_default_ticks();
        send_tick(0, 1023, 1'b1);
        send_tick(17, 1023, 1'b1);
        repeat (4) send_tick(1023, 1023, 1'b1);
        send_tick(1023, 0, 1'b1);
        send_tick(9, 512, 1'b0);
        repeat (2) send_tick(17, 1023, 1'b1);
        send_tick(17, 1023, 1'b0);
        wait_results_drained();
    endtask

    task automatic test_window_corners();
        // empty window
        write_reg(CFG_THROTTLE_LOW, 300);
        write_reg(CFG_THROTTLE_HIGH, 300);
        send_tick(0, 1023, 1'b1);
        send_tick(1023, 700, 1'b1);
        send_tick(500, 0, 1'b1);
        wait_results_drained();
        // inverted window
        write_reg(CFG_THROTTLE_LOW, 800);
        write_reg(CFG_THROTTLE_HIGH, 200);
        send_tick(1023, 1023, 1'b1);
        send_tick(0, 1023, 1'b1);
        send_tick(500, 1023, 1'b1);
        wait_results_drained();
        // throttle below and far above the window
        write_reg(CFG_THROTTLE_LOW, 100);
        write_reg(CFG_THROTTLE_HIGH, 200);
        send_tick(50, 1023, 1'b1);
        send_tick(1023, 1023, 1'b1);
        wait_results_drained();
        // minimum speed above the ceiling
        write_reg(CFG_MIN_SPEED, 200);
        write_reg(CFG_THROTTLE_LOW, 0);
        write_reg(CFG_THROTTLE_HIGH, 100);
        repeat (2) send_tick(1023, 400, 1'b1);
        send_tick(0, 400, 1'b0);
        wait_results_drained();
        // write to an unused index must not touch any register
        write_reg(CFG_UNUSED, 16'hFFFF);
        send_tick(1023, 1023, 1'b1);
        wait_results_drained();
    endtask

    task automatic test_random_settings();
        t_cfg c;
        for (int p = 0; p < 6; p++) begin
            case (p)
                0: c = '{accel_step: 16'd2048, coast_step: 16'd1365, brake_step: 16'd6400,
                         min_speed: 8'd20, throttle_low: 10'd0, throttle_high: 10'd1023,
                         idle_limit: 16'hFFFF};
                1: c = '{accel_step: 16'hFFFF, coast_step: 16'hFFFF, brake_step: 16'hFFFF,
                         min_speed: 8'd254, throttle_low: 10'd1023, throttle_high: 10'd0,
                         idle_limit: $urandom_range(5000, 65535)};
                2: c = '{accel_step: 16'd0, coast_step: 16'd0, brake_step: 16'd0,
                         min_speed: 8'd0, throttle_low: 10'd0, throttle_high: 10'd0,
                         idle_limit: 16'd5000};
                default: begin
                    c.accel_step    = $urandom_range(16, 8192);
                    c.coast_step    = $urandom_range(16, 8192);
                    c.brake_step    = $urandom_range(256, 16384);
                    c.min_speed     = $urandom_range(0, 60);
                    c.throttle_low  = $urandom_range(0, 400);
                    c.throttle_high = $urandom_range(300, 1023);
                    c.idle_limit    = $urandom_range(5000, 65535);
                end
            endcase
            send_gaps   = (p != 3);
            recv_stalls = (p != 3);
            apply_cfg(c);
            drive_random(250);
            wait_results_drained();
        end
    endtask

    task automatic test_idle_run();
        t_cfg c;
        c               = cfg_shadow;
        c.throttle_low  = 10'd0;
        c.throttle_high = 10'd0;
        c.idle_limit    = 16'hFFFF;
        send_gaps   = 1'b0;
        recv_stalls = 1'b0;
        apply_cfg(c);
        // top readings up to 4 give a zero ceiling, so every tick is idle
        for (int n = 0; n < 30; n++) begin
            send_tick($urandom_range(0, 1023), $urandom_range(0, 4), 1'b1);
        end
        wait_results_drained();
    endtask

    task automatic test_power_off();
        t_cfg c;
        c.accel_step    = $urandom_range(256, 4096);
        c.coast_step    = $urandom_range(256, 4096);
        c.brake_step    = $urandom_range(256, 8192);
        c.min_speed     = $urandom_range(0, 40);
        c.throttle_low  = $urandom_range(0, 200);
        c.throttle_high = $urandom_range(600, 1023);
        c.idle_limit    = 16'd0;
        send_gaps   = 1'b1;
        recv_stalls = 1'b1;
        apply_cfg(c);
        drive_random(75);
        wait_results_drained();
        send_gaps   = 1'b0;
        recv_stalls = 1'b0;
        drive_random(75);
    endtask

    // Receiver: stall in bursts while enabled.
    initial begin
        i_stall = 1'b0;
        forever begin
            @(negedge i_clk);
            if (recv_stalls && $urandom_range(0, 7) == 0) begin
                i_stall <= 1'b1;
                repeat ($urandom_range(1, 15)) @(negedge i_clk);
                i_stall <= 1'b0;
            end
        end
    end

    always @(posedge i_clk) begin : check_result
        t_tick_result got;
        t_tick_result want;
        if (i_rst_n && o_valid && !i_stall) begin
            got = '{o_pwm_duty, o_speed_ceiling, o_power_off};
            if (expected_ticks.size() == 0) begin
                mismatches++;
                if (mismatches <= 10) begin
                    $display("unexpected word: duty %0d ceiling %0d power_off %0b",
                             got.pwm_duty, got.speed_ceiling, got.power_off);
                end
            end else begin
                want = expected_ticks.pop_front();
                if (got.pwm_duty !== want.pwm_duty || got.speed_ceiling !== want.speed_ceiling
                    || got.power_off !== want.power_off) begin
                    mismatches++;
                    if (mismatches <= 10) begin
                        $display("mismatch: duty %0d/%0d ceiling %0d/%0d power_off %0b/%0b",
                                 want.pwm_duty, got.pwm_duty, want.speed_ceiling,
                                 got.speed_ceiling, want.power_off, got.power_off);
                    end
                end
            end
        end
    end

    initial begin
        i_rst_n           = 1'b0;
        i_valid           = 1'b0;
        i_throttle_sample = '0;
        i_top_sample      = '0;
        i_brake_released  = 1'b1;
        i_cfg_valid       = 1'b0;
        i_cfg_index       = CFG_ACCEL_STEP;
        i_cfg_data        = '0;
        cfg_shadow = '{accel_step: RST_ACCEL_STEP, coast_step: RST_COAST_STEP,
                       brake_step: RST_BRAKE_STEP, min_speed: RST_MIN_SPEED,
                       throttle_low: RST_THROTTLE_LOW, throttle_high: RST_THROTTLE_HIGH,
                       idle_limit: RST_IDLE_LIMIT};
        motor_speed = 0;
        idle_count  = 0;
        power_cut   = 1'b0;
        repeat (5) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        test_default_ticks();
        test_window_corners();
        test_random_settings();
        test_idle_run();
        test_power_off();

        wait_results_drained();
        repeat (50) @(posedge i_clk);
        if (mismatches == 0 && expected_ticks.size() == 0) begin
            $display("** throttle_ramp_speed_controller_top: PASSED **");
        end else begin
            $display("** throttle_ramp_speed_controller_top: FAILED **");
        end
        $finish;
    end

    initial begin
        #100_000_000;
        $display("** throttle_ramp_speed_controller_top: FAILED **");
        $finish;
    end

endmodule

// ----- files.f -----
hdl/trsc_pkg.sv
hdl/trsc_div.sv
hdl/trsc_state.sv
hdl/throttle_ramp_speed_controller_top.sv
hdl/trsc_checker.sv
tb/sv/throttle_ramp_speed_controller_top_test.sv
